>>> sv/fra_pkg.sv
// Shared types, widths and status codes for the fenced ring slot allocator.
`timescale 1ns / 1ps
package fra_pkg;

  localparam int FENCE_W    = 64;
  localparam int RUN_W      = 11;
  localparam int SLOT_OUT_W = 10;
  localparam int ST_W       = 2;
  localparam int SLOTS_DEF  = 1024;
  localparam int RUN_MAX    = 2047;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [RUN_W-1:0] RING_SIZE_RST = 11'd1024;
  localparam logic             REG_RING_SIZE = 1'b0;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_LEN = 2'd1;
  localparam logic [ST_W-1:0] ST_FENCE   = 2'd2;

  typedef struct packed {
    logic [RUN_W-1:0]   run_length;
    logic [FENCE_W-1:0] current_fence;
  } fra_in_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] first_slot;
    logic [FENCE_W-1:0]    wait_fence;
    logic [ST_W-1:0]       status;
  } fra_out_t;

  typedef struct packed {
    logic [RUN_W-1:0] ring_size;
    logic             clear;
  } fra_cfg_t;

endpackage

>>> sv/fra_slot_mem.sv
// Slot fence store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module fra_slot_mem #(
  parameter int DEPTH = fra_pkg::SLOTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [fra_pkg::FENCE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [fra_pkg::FENCE_W-1:0] rdata
);
  import fra_pkg::*;

  logic [FENCE_W-1:0] mem [DEPTH];
  logic [FENCE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/fra_cfg_regs.sv
// APB register block: ring_size register and store clear strobe.
`timescale 1ns / 1ps
module fra_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fra_pkg::CFG_AW-1:0] paddr,
  input  logic [fra_pkg::CFG_DW-1:0] pwdata,
  output logic [fra_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output fra_pkg::fra_cfg_t          cfg
);
  import fra_pkg::*;

  logic             reg_idx;
  logic             wr_en;
  logic [RUN_W-1:0] ring_size_r;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_RING_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= RING_SIZE_RST;
    end else if (wr_en) begin
      ring_size_r <= pwdata[RUN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_RING_SIZE) begin
      prdata = {{(CFG_DW-RUN_W){1'b0}}, ring_size_r};
    end
  end

  assign cfg.ring_size = ring_size_r;
  assign cfg.clear     = wr_en;

endmodule

>>> sv/fenced_ring_slot_allocator_core.sv
// Top level: fence-guarded ring allocator for contiguous runs of slots.
`timescale 1ns / 1ps
// Usage:
//   in_*   : request beat (run_length, current_fence), valid/ready.
//   out_*  : one result beat per request (first_slot, wait_fence, status).
//   cfg_*  : APB port; ring_size at byte address 0. A write to it clears the
//            slot store and the position.
// Result path: an accepted request passes the lookup and response states;
//   out_valid rises as the result loads, provided the output register is free.
// Throughput: one request at a time. An error result frees the block as soon
//   as it is loaded; a good one then stamps the run through the slot memory's
//   single write port, one slot per cycle.
// Reset and ring_size writes start a clearing pass that zeroes every slot of
//   the slot memory; in_ready stays low during it.
// A stalled receiver holds the result in the output register; the block
//   finishes stamping and may take the next request, but holds its result
//   until the previous beat is taken.
module fenced_ring_slot_allocator_core #(
  parameter int SLOTS = fra_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fra_pkg::fra_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fra_pkg::fra_out_t          out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [fra_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fra_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fra_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import fra_pkg::*;

  localparam int AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SIZE_CAP = (SLOTS < RUN_MAX) ? SLOTS : RUN_MAX;
  localparam logic [RUN_W-1:0] SIZE_CAP_V = RUN_W'(SIZE_CAP);
  localparam logic [AW-1:0]    CLR_LAST   = AW'(SLOTS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_RESP  = 2'd2;
  localparam logic [1:0] S_STAMP = 2'd3;

  fra_cfg_t cfg;

  logic [1:0]         state_r;
  logic               clr_active_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [RUN_W-1:0]   next_pos_r;
  logic [RUN_W-1:0]   req_len_r;
  logic [FENCE_W-1:0] req_fence_r;
  logic [RUN_W-1:0]   start_r;
  logic               bad_r;
  logic [RUN_W-1:0]   stamp_cnt_r;
  logic               out_valid_r;
  fra_out_t           out_data_r;

  logic [RUN_W-1:0]   size_w;
  logic               bad_w;
  logic [RUN_W:0]     end_w;
  logic               wrap_w;
  logic [RUN_W-1:0]   start_w;
  logic [RUN_W-1:0]   last_w;
  logic [FENCE_W-1:0] stored_w;
  logic               fence_fail_w;
  logic               out_free_w;
  logic               stamp_last_w;
  fra_out_t           res_w;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [FENCE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [FENCE_W-1:0] mem_rdata;

  fra_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  fra_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Request decode from registered beat
  assign size_w  = (cfg.ring_size > SIZE_CAP_V) ? SIZE_CAP_V : cfg.ring_size;
  assign bad_w   = (req_len_r == '0) || (req_len_r > size_w);
  assign end_w   = {1'b0, next_pos_r} + {1'b0, req_len_r};
  assign wrap_w  = end_w > {1'b0, size_w};
  assign start_w = wrap_w ? '0 : next_pos_r;
  assign last_w  = start_w + req_len_r - RUN_W'(1);

  assign stored_w     = bad_r ? '0 : mem_rdata;
  assign fence_fail_w = stored_w >= req_fence_r;
  assign out_free_w   = !out_valid_r || out_ready;
  assign stamp_last_w = (stamp_cnt_r == req_len_r - RUN_W'(1));

  always_comb begin
    res_w.first_slot = bad_r ? '0 : start_r[SLOT_OUT_W-1:0];
    res_w.wait_fence = stored_w;
    if (bad_r) begin
      res_w.status = ST_BAD_LEN;
    end else if (fence_fail_w) begin
      res_w.status = ST_FENCE;
    end else begin
      res_w.status = ST_OK;
    end
  end

  // Memory ports: reads only in lookup, writes only while clearing or stamping
  assign mem_re    = (state_r == S_LOOK) && !bad_w;
  assign mem_raddr = AW'(last_w);
  assign mem_we    = clr_active_r || (state_r == S_STAMP);
  assign mem_waddr = clr_active_r ? clr_cnt_r : AW'(start_r + stamp_cnt_r);
  assign mem_wdata = clr_active_r ? '0 : req_fence_r;

  assign in_ready  = (state_r == S_IDLE) && !clr_active_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (cfg.clear) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == CLR_LAST) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_pos_r  <= '0;
      out_valid_r <= 1'b0;
      stamp_cnt_r <= '0;
      bad_r       <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg.clear) begin
        next_pos_r <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req_len_r   <= in_data.run_length;
            req_fence_r <= in_data.current_fence;
            state_r     <= S_LOOK;
          end
        end
        S_LOOK: begin
          bad_r   <= bad_w;
          start_r <= start_w;
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_free_w) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_w;
            stamp_cnt_r <= '0;
            state_r     <= (res_w.status == ST_OK) ? S_STAMP : S_IDLE;
          end
        end
        S_STAMP: begin
          stamp_cnt_r <= stamp_cnt_r + RUN_W'(1);
          if (stamp_last_w) begin
            next_pos_r <= start_r + req_len_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("slot memory read and write in the same cycle");

  a_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    next_pos_r <= size_w)
    else $error("position past effective ring size");

  a_stamp_not_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STAMP) |-> !clr_active_r)
    else $error("stamping during clearing pass");

  a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_BAD_LEN) |->
      (out_data_r.first_slot == '0 && out_data_r.wait_fence == '0))
    else $error("bad length result carries nonzero payload");

  a_stamp_after_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RESP) && out_free_w && (res_w.status == ST_OK)) |=>
      (state_r == S_STAMP && out_data_r.status == ST_OK))
    else $error("good result not followed by stamping");

endmodule
